@@ hdl/top_k_select_stream_defines.svh @@
// Assertion macros for the top-k selection RTL
`ifndef TOP_K_SELECT_STREAM_DEFINES_SVH
`define TOP_K_SELECT_STREAM_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TKS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TKS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tks_pkg.sv @@
// Shared constants for the top-k selection block
package tks_pkg;

	localparam int KEEP_MAX_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;
	localparam int ROW_MAX_DEF    = 65536;

	localparam int VALUE_W    = 32;
	localparam int INDEX_W    = 16;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_ADDR_W-1:0] REG_KEEP_COUNT   = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_LARGEST_MODE = 1'b1;

endpackage

@@ hdl/tks_drain.sv @@
// Result buffer: holds one finished row and hands it out best first
`include "top_k_select_stream_defines.svh"

module tks_drain #(
	parameter int KEEP_MAX   = tks_pkg::KEEP_MAX_DEF,
	parameter int VALUE_BITS = tks_pkg::VALUE_BITS_DEF,
	parameter int KPOS_W     = tks_pkg::INDEX_W,
	parameter int KW         = $clog2(KEEP_MAX + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic [KW-1:0]                        load_cnt,
	input  logic                                 load_ovf,
	input  logic [VALUE_BITS-1:0]                load_val [KEEP_MAX],
	input  logic [KPOS_W-1:0]                    load_pos [KEEP_MAX],
	output logic                                 free,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [tks_pkg::VALUE_W-1:0]   out_value,
	output logic [tks_pkg::INDEX_W-1:0]          out_index,
	output logic                                 out_last,
	output logic                                 out_overflow
);

	logic [VALUE_BITS-1:0] buf_val_q [KEEP_MAX];
	logic [KPOS_W-1:0]     buf_pos_q [KEEP_MAX];
	logic [KW-1:0]         cnt_q;
	logic                  ovf_q;

	assign out_valid    = (cnt_q != '0);
	assign out_last     = (cnt_q == KW'(1));
	assign out_overflow = ovf_q;
	assign out_value    = tks_pkg::VALUE_W'(buf_val_q[0]);
	assign out_index    = tks_pkg::INDEX_W'(buf_pos_q[0]);
	assign free         = (cnt_q == '0) || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (load) begin
			cnt_q <= load_cnt;
			ovf_q <= load_ovf;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - KW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_val_q <= load_val;
			buf_pos_q <= load_pos;
		end else if (out_valid && out_ready) begin
			for (int i = 0; i < KEEP_MAX - 1; i++) begin
				buf_val_q[i] <= buf_val_q[i+1];
				buf_pos_q[i] <= buf_pos_q[i+1];
			end
		end
	end

	`TKS_ASSERT_IMP(a_load_when_free, load, free, "row loaded over undelivered results")
	`TKS_ASSERT_IMP(a_load_nonempty, load, load_cnt != '0, "row loaded with no results")
	`TKS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= KW'(KEEP_MAX), "result count above capacity")
	`TKS_ASSERT_NXT(a_last_empties, out_valid && out_ready && out_last && !load, !out_valid, "results continue past last")

endmodule

@@ hdl/top_k_select_stream.sv @@
// Top level of the streaming top-k selector
// Streaming top-k selector. Takes one signed value per cycle; a value is
// compared against all kept entries at once and inserted in rank order in
// the same cycle, so non-final items flow at one per cycle. The item with
// row_end copies the kept list into a result buffer, which hands out
// min(row length, keep_count clamped to 1..KEEP_MAX) results, best first,
// one per cycle while out_ready is high, as the next row streams in. A
// row_end item waits only while the previous row's results are still in
// the buffer, up to the cycle its last result transfers. Elements at
// positions ROW_MAX and up are ignored and set that row's out_overflow.
module top_k_select_stream #(
	parameter int KEEP_MAX   = tks_pkg::KEEP_MAX_DEF,
	parameter int VALUE_BITS = tks_pkg::VALUE_BITS_DEF,
	parameter int ROW_MAX    = tks_pkg::ROW_MAX_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [tks_pkg::CFG_ADDR_W-1:0]         cfg_addr,
	input  logic [tks_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tks_pkg::VALUE_W-1:0]     value_in,
	input  logic                                   row_end,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [tks_pkg::VALUE_W-1:0]     out_value,
	output logic [tks_pkg::INDEX_W-1:0]            out_index,
	output logic                                   out_last,
	output logic                                   out_overflow
);

	localparam int KW     = $clog2(KEEP_MAX + 1);
	localparam int IW     = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
	localparam int POS_W  = $clog2(ROW_MAX + 1);
	localparam int KPOS_W = (POS_W < tks_pkg::INDEX_W) ? POS_W : tks_pkg::INDEX_W;
	localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [KW-1:0]         K_LIMIT  = KW'(KEEP_MAX);

	logic [tks_pkg::CFG_DATA_W-1:0] keep_count_q;
	logic                           largest_mode_q;

	logic [VALUE_BITS-1:0] kept_val_q [KEEP_MAX];
	logic [KPOS_W-1:0]     kept_pos_q [KEEP_MAX];
	logic [KW-1:0]         kept_cnt_q;
	logic [POS_W-1:0]      row_pos_q;
	logic                  ovf_q;

	logic [VALUE_BITS-1:0] v;
	logic [VALUE_BITS-1:0] v_key;
	logic [KW-1:0]         k_eff;
	logic [KW-1:0]         km1;
	logic [KW-1:0]         kc;
	logic [KEEP_MAX-1:0]   bet;
	logic [KEEP_MAX-1:0]   pre;
	logic                  ovf_item;
	logic                  take;
	logic                  accept;
	logic                  drain_free;
	logic [VALUE_BITS-1:0] nxt_val [KEEP_MAX];
	logic [KPOS_W-1:0]     nxt_pos [KEEP_MAX];
	logic [KW-1:0]         nxt_cnt;

	assign in_ready = !row_end || drain_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q   <= tks_pkg::CFG_DATA_W'(1);
			largest_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				tks_pkg::REG_KEEP_COUNT:   keep_count_q   <= cfg_wdata;
				tks_pkg::REG_LARGEST_MODE: largest_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		v     = VALUE_BITS'($unsigned(value_in));
		v_key = v ^ SIGN_BIT;
		if (keep_count_q == '0) begin
			k_eff = KW'(1);
		end else if (int'(keep_count_q) > KEEP_MAX) begin
			k_eff = K_LIMIT;
		end else begin
			k_eff = KW'(keep_count_q);
		end
		km1      = k_eff - KW'(1);
		kc       = (kept_cnt_q > k_eff) ? k_eff : kept_cnt_q;
		ovf_item = (row_pos_q >= POS_W'(ROW_MAX));
		for (int i = 0; i < KEEP_MAX; i++) begin
			bet[i] = largest_mode_q ? (v_key > (kept_val_q[i] ^ SIGN_BIT))
			                        : (v_key < (kept_val_q[i] ^ SIGN_BIT));
		end
		for (int i = 0; i < KEEP_MAX; i++) begin
			pre[i] = (bet[i] && (KW'(i) < kc)) || ((i > 0) ? pre[(i > 0) ? i-1 : 0] : 1'b0);
		end
		take = !ovf_item && ((kc < k_eff) || bet[km1[IW-1:0]]);
		for (int i = 0; i < KEEP_MAX; i++) begin
			nxt_val[i] = kept_val_q[i];
			nxt_pos[i] = kept_pos_q[i];
			if (take) begin
				if (i > 0 && pre[(i > 0) ? i-1 : 0]) begin
					nxt_val[i] = kept_val_q[(i > 0) ? i-1 : 0];
					nxt_pos[i] = kept_pos_q[(i > 0) ? i-1 : 0];
				end else if (pre[i] || (KW'(i) == kc)) begin
					nxt_val[i] = v;
					nxt_pos[i] = KPOS_W'(row_pos_q);
				end
			end
		end
		if (take && (kc != k_eff)) begin
			nxt_cnt = kc + KW'(1);
		end else begin
			nxt_cnt = kc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_cnt_q <= '0;
			row_pos_q  <= '0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				kept_cnt_q <= '0;
				row_pos_q  <= '0;
				ovf_q      <= 1'b0;
			end else begin
				kept_cnt_q <= nxt_cnt;
				ovf_q      <= ovf_q || ovf_item;
				if (!ovf_item) begin
					row_pos_q <= row_pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kept_val_q <= nxt_val;
			kept_pos_q <= nxt_pos;
		end
	end

	tks_drain #(
		.KEEP_MAX   (KEEP_MAX),
		.VALUE_BITS (VALUE_BITS),
		.KPOS_W     (KPOS_W),
		.KW         (KW)
	) u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept && row_end),
		.load_cnt     (nxt_cnt),
		.load_ovf     (ovf_q || ovf_item),
		.load_val     (nxt_val),
		.load_pos     (nxt_pos),
		.free         (drain_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.out_index    (out_index),
		.out_last     (out_last),
		.out_overflow (out_overflow)
	);

endmodule
